@@ sv/bgc_pkg.sv @@
// Package for the backlight gamma controller: widths, codes, command/status
// structs and the small constant tables used by the controller and datapath.
// No dependencies.
package bgc_pkg;

	localparam int unsigned LEVEL_W       = 8;
	localparam int unsigned FUNC_W        = 2;
	localparam int unsigned GAMMA_W       = 9;
	localparam int unsigned EXP_W         = 3;   // integer part of gamma, 0..5
	localparam int unsigned FRAC_W        = 7;   // hundredths of gamma, 0..99
	localparam int unsigned PROD_W        = 48;  // holds x^6 for x <= 254
	localparam int unsigned POW_W         = 40;  // holds 255^5
	localparam int unsigned MIX_W         = 15;  // holds 255 * 100
	localparam int unsigned QUO_W         = 8;   // every quotient here is below 256
	localparam int unsigned CNT_W         = $clog2(QUO_W);
	localparam int unsigned RECIP_W       = 13;   // divide-by-100 multiplier width
	localparam int unsigned RECIP_100     = 5243; // ceil(2^19 / 100), exact below 43690
	localparam int unsigned RECIP_SH      = 19;
	localparam int unsigned DEFAULT_LEVEL = 128;
	localparam int unsigned GAMMA_UNITY   = 100;
	localparam int unsigned GAMMA_RESET   = 100;
	localparam int unsigned FRAC_ONE      = 100;
	localparam int unsigned LEVEL_MAX     = 255;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_SET     = 2'd0,
		FUNC_OFF     = 2'd1,
		FUNC_ON      = 2'd2,
		FUNC_REFRESH = 2'd3
	} func_t;

	typedef enum logic {
		DIV_LO = 1'b0,
		DIV_HI = 1'b1
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     mul;
		logic     div_start;
		div_sel_t div_sel;
		logic     div_step;
		logic     lo_save;
		logic     mix;
		logic     fin;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic             emit;
		logic             bypass;
		logic [EXP_W-1:0] n;
		logic             out_free;
	} dp_stat_t;

	// 255^e for e = 0..5
	function automatic logic [POW_W-1:0] pow255(input logic [EXP_W-1:0] e);
		logic [POW_W-1:0] r;
		case (e)
			3'd0:    r = 40'd1;
			3'd1:    r = 40'd255;
			3'd2:    r = 40'd65025;
			3'd3:    r = 40'd16581375;
			3'd4:    r = 40'd4228250625;
			3'd5:    r = 40'd1078203909375;
			default: r = 40'd1;
		endcase
		return r;
	endfunction

	// integer part of gamma/100 over the 9-bit range
	function automatic logic [EXP_W-1:0] gamma_int(input logic [GAMMA_W-1:0] g);
		logic [EXP_W-1:0] n;
		if (g >= 9'd500)
			n = 3'd5;
		else if (g >= 9'd400)
			n = 3'd4;
		else if (g >= 9'd300)
			n = 3'd3;
		else if (g >= 9'd200)
			n = 3'd2;
		else if (g >= 9'd100)
			n = 3'd1;
		else
			n = 3'd0;
		return n;
	endfunction

endpackage

@@ sv/bgc_if.sv @@
// Request and result channel interfaces of the backlight gamma controller.
// Depends on bgc_pkg.
interface bgc_req_if;
	logic                         valid;
	logic                         ready;
	logic [bgc_pkg::FUNC_W-1:0]   func;
	logic [bgc_pkg::LEVEL_W-1:0]  level;

	modport source (output valid, output func, output level, input ready);
	modport sink   (input valid, input func, input level, output ready);
endinterface

interface bgc_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [bgc_pkg::LEVEL_W-1:0]  device_level;
	logic                         display_on;

	modport source (output valid, output device_level, output display_on, input ready);
	modport sink   (input valid, input device_level, input display_on, output ready);
endinterface

@@ sv/bgc_ctrl.sv @@
// Sequencer of the backlight gamma controller: walks the power, divide and
// blend steps of one request. Depends on bgc_pkg.
module bgc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  bgc_pkg::dp_stat_t stat,
	output bgc_pkg::dp_cmd_t  cmd
);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_DECIDE = 10'b00_0000_0010,
		S_POW    = 10'b00_0000_0100,
		S_DLO    = 10'b00_0000_1000,
		S_DHI_M  = 10'b00_0001_0000,
		S_DHI_S  = 10'b00_0010_0000,
		S_DHI    = 10'b00_0100_0000,
		S_MIX    = 10'b00_1000_0000,
		S_FIN    = 10'b01_0000_0000,
		S_OUT    = 10'b10_0000_0000
	} state_t;

	localparam logic [bgc_pkg::CNT_W-1:0] LAST_STEP = bgc_pkg::CNT_W'(bgc_pkg::QUO_W - 1);

	state_t                       state_q, state_d;
	logic [bgc_pkg::EXP_W-1:0]    pow_q, pow_d;   // power of x held in the product register
	logic [bgc_pkg::CNT_W-1:0]    cnt_q, cnt_d;   // divider step

	always_comb begin
		state_d   = state_q;
		pow_d     = pow_q;
		cnt_d     = cnt_q;
		cmd       = '0;
		cmd.div_sel = bgc_pkg::DIV_LO;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				pow_d = bgc_pkg::EXP_W'(1);
				if (!stat.emit) begin
					state_d = S_IDLE;
				end else if (stat.bypass) begin
					state_d = S_OUT;
				end else if (stat.n == '0) begin
					// low end is full scale, high end is x itself
					cmd.lo_save   = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = bgc_pkg::DIV_HI;
					cnt_d         = '0;
					state_d       = S_DHI;
				end else begin
					state_d = S_POW;
				end
			end
			S_POW: begin
				if (pow_q < stat.n) begin
					cmd.mul = 1'b1;
					pow_d   = pow_q + 1'b1;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = bgc_pkg::DIV_LO;
					cnt_d         = '0;
					state_d       = S_DLO;
				end
			end
			S_DLO: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == LAST_STEP)
					state_d = S_DHI_M;
			end
			S_DHI_M: begin
				cmd.mul     = 1'b1;
				cmd.lo_save = 1'b1;
				state_d     = S_DHI_S;
			end
			S_DHI_S: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = bgc_pkg::DIV_HI;
				cnt_d         = '0;
				state_d       = S_DHI;
			end
			S_DHI: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == LAST_STEP)
					state_d = S_MIX;
			end
			S_MIX: begin
				cmd.mix = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pow_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			pow_q   <= pow_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

@@ sv/bgc_dp.sv @@
// Datapath of the backlight gamma controller: state, gamma register, power
// multiplier, radix-2 divider, blend and result register. Depends on bgc_pkg, bgc_if.
module bgc_dp #(
	parameter int unsigned DEFAULT_LEVEL = bgc_pkg::DEFAULT_LEVEL
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bgc_pkg::dp_cmd_t              cmd,
	output bgc_pkg::dp_stat_t             stat,
	input  logic [bgc_pkg::FUNC_W-1:0]    req_func,
	input  logic [bgc_pkg::LEVEL_W-1:0]   req_level,
	input  logic                          cfg_we,
	input  logic [bgc_pkg::GAMMA_W-1:0]   cfg_wdata,
	bgc_rsp_if.source                     rsp
);

	localparam int unsigned LW = bgc_pkg::LEVEL_W;
	localparam int unsigned PW = bgc_pkg::PROD_W;
	localparam int unsigned QW = bgc_pkg::QUO_W;
	localparam int unsigned MW = bgc_pkg::MIX_W;
	localparam int unsigned FW = bgc_pkg::FRAC_W;
	localparam int unsigned GW = bgc_pkg::GAMMA_W;
	localparam int unsigned EW = bgc_pkg::EXP_W;
	localparam int unsigned RW = bgc_pkg::RECIP_W;
	localparam int unsigned XW = MW + RW;

	// control state
	logic [GW-1:0]  gamma_q;
	logic [LW-1:0]  level_q;
	logic           active_q;
	logic           rsp_valid_q;

	// per-request payload
	logic [LW-1:0]  x_q;
	logic [EW-1:0]  n_q;
	logic [FW-1:0]  f_q;
	logic           emit_q;
	logic           bypass_q;
	logic           disp_q;
	logic [PW-1:0]  p_q;
	logic [PW-1:0]  rem_q;
	logic [PW-1:0]  dsh_q;
	logic [QW-1:0]  quo_q;
	logic [LW-1:0]  lo_q;
	logic [MW-1:0]  pa_q;
	logic [MW-1:0]  pb_q;
	logic [LW-1:0]  fin_q;
	logic [LW-1:0]  rsp_level_q;
	logic           rsp_on_q;

	// request decode
	bgc_pkg::func_t  func;
	logic [LW-1:0]   x_new;
	logic            active_new;
	logic            emit_new;
	logic            disp_new;
	logic            bypass_new;
	logic [EW-1:0]   n_new;
	logic [GW-1:0]   n_hund;

	logic [PW+LW-1:0]           mul_full;
	logic [bgc_pkg::POW_W-1:0]  div_d;
	logic                       ge;
	logic [FW-1:0]              f_inv;
	logic [MW-1:0]              mix_sum;
	logic [XW-1:0]              fin_prod;

	always_comb begin
		func       = bgc_pkg::func_t'(req_func);
		x_new      = level_q;
		active_new = active_q;
		emit_new   = active_q;
		disp_new   = 1'b1;
		case (func)
			bgc_pkg::FUNC_SET: begin
				x_new = req_level;
			end
			bgc_pkg::FUNC_OFF: begin
				x_new      = '0;
				active_new = 1'b0;
				emit_new   = 1'b1;
				disp_new   = 1'b0;
			end
			bgc_pkg::FUNC_ON: begin
				active_new = 1'b1;
				emit_new   = 1'b1;
			end
			default: begin
			end
		endcase
		bypass_new = (x_new == '0) || (x_new == LW'(bgc_pkg::LEVEL_MAX)) ||
			(gamma_q == GW'(bgc_pkg::GAMMA_UNITY));
		n_new  = bgc_pkg::gamma_int(gamma_q);
		n_hund = GW'(int'(n_new) * int'(bgc_pkg::FRAC_ONE));
	end

	assign mul_full = p_q * x_q;
	assign ge       = (rem_q >= dsh_q);
	assign f_inv    = FW'(bgc_pkg::FRAC_ONE) - f_q;

	// blend sum is at most 255 * 100, so no carry out
	assign mix_sum  = pa_q + pb_q;
	// divide by 100 as a reciprocal multiply, exact over the blend range
	assign fin_prod = XW'(mix_sum) * XW'(bgc_pkg::RECIP_100);

	always_comb begin
		case (cmd.div_sel)
			bgc_pkg::DIV_LO: begin
				div_d = bgc_pkg::pow255(n_q - 1'b1);
			end
			default: begin
				div_d = bgc_pkg::pow255(n_q);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q     <= GW'(bgc_pkg::GAMMA_RESET);
			level_q     <= LW'(DEFAULT_LEVEL);
			active_q    <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				gamma_q <= cfg_wdata;
			if (cmd.load) begin
				if (func == bgc_pkg::FUNC_SET)
					level_q <= req_level;
				active_q <= active_new;
			end
			if (cmd.out_load)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q      <= x_new;
			n_q      <= n_new;
			f_q      <= FW'(gamma_q - n_hund);
			emit_q   <= emit_new;
			bypass_q <= bypass_new;
			disp_q   <= disp_new;
			p_q      <= PW'(x_new);
		end else if (cmd.mul) begin
			p_q <= mul_full[PW-1:0];
		end

		// quotient is known to fit in QW bits, so only QW restoring steps
		if (cmd.div_start) begin
			rem_q <= p_q;
			dsh_q <= PW'(div_d) << (QW - 1);
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (ge)
				rem_q <= rem_q - dsh_q;
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[QW-2:0], ge};
		end

		if (cmd.lo_save)
			lo_q <= (n_q == '0) ? LW'(bgc_pkg::LEVEL_MAX) : quo_q;

		if (cmd.mix) begin
			pa_q <= MW'(lo_q) * MW'(f_inv);
			pb_q <= MW'(quo_q) * MW'(f_q);
		end

		if (cmd.fin)
			fin_q <= fin_prod[bgc_pkg::RECIP_SH +: LW];

		// blend of two values at most full scale cannot exceed full scale
		if (cmd.out_load) begin
			rsp_level_q <= bypass_q ? x_q : fin_q;
			rsp_on_q    <= disp_q;
		end
	end

	assign stat.emit     = emit_q;
	assign stat.bypass   = bypass_q;
	assign stat.n        = n_q;
	assign stat.out_free = !rsp_valid_q || rsp.ready;

	assign rsp.valid        = rsp_valid_q;
	assign rsp.device_level = rsp_level_q;
	assign rsp.display_on   = rsp_on_q;

endmodule

@@ sv/backlight_gamma_controller.sv @@
// Backlight gamma controller, top level.
// Depends on bgc_pkg, bgc_if, bgc_ctrl and bgc_dp.
//
// Use: each request on req carries func (set level, screen off, screen on,
// refresh) and level. The block keeps the stored level and a screen-on flag
// and answers on rsp with device_level = 255*(x/255)^(gamma/100), blended
// linearly over the hundredths of gamma, plus display_on. A set or refresh
// while the screen is off yields no result; screen off yields level 0.
// The gamma exponent (times 100) is written through cfg_we/cfg_wdata; the user
// must write it only while idle, which the block itself does not enforce.
// Sequencing: one request at a time; req.ready is high only while idle.
// Levels 0 and 255 and unity gamma reach the result register straight from
// the decide state. Otherwise, for integer gamma part n >= 1, the steps are:
// n multiplies by x, 8-step restoring divisions by 255^(n-1) and 255^n
// through one shared divider, the blend and a reciprocal divide by 100;
// gamma below 1.00 skips the multiplies and the first division.
// A dropped set or refresh on a dark screen returns from decide to idle.
// Reset clears the sequencer and result valid, loads gamma 1.00, the
// default level and screen on. A stalled rsp holds its result; the next
// request is still taken and its result waits in the sequencer until free.
module backlight_gamma_controller #(
	parameter int unsigned DEFAULT_LEVEL = bgc_pkg::DEFAULT_LEVEL
) (
	input  logic                          clk,
	input  logic                          arst_n,
	bgc_req_if.sink                       req,
	bgc_rsp_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [bgc_pkg::GAMMA_W-1:0]   cfg_wdata
);

	bgc_pkg::dp_cmd_t   cmd;
	bgc_pkg::dp_stat_t  stat;
	logic               req_ready;

	assign req.ready = req_ready;

	// sequencer: decides which datapath step runs each cycle
	bgc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: state, multiplier, divider and result register
	bgc_dp #(
		.DEFAULT_LEVEL (DEFAULT_LEVEL)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req_func  (req.func),
		.req_level (req.level),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rsp       (rsp)
	);

endmodule

@@ verif/backlight_gamma_controller_tb.sv @@
// Self-checking testbench for backlight_gamma_controller: gamma-corrected
// level requests, screen on/off and refresh, checked against an in-bench model.
// Depends on bgc_pkg, bgc_if and the controller RTL.
`timescale 1ns / 1ps

typedef struct packed {
	logic [bgc_pkg::LEVEL_W-1:0] device_level;
	logic                        display_on;
} panel_result_t;

class panel_scoreboard;
	logic [bgc_pkg::GAMMA_W-1:0] gamma_cur;
	logic [bgc_pkg::LEVEL_W-1:0] stored_level;
	logic                        lit;
	panel_result_t               pending_results[$];
	int unsigned                 errors;

	function new();
		gamma_cur    = bgc_pkg::GAMMA_W'(bgc_pkg::GAMMA_RESET);
		stored_level = bgc_pkg::LEVEL_W'(bgc_pkg::DEFAULT_LEVEL);
		lit          = 1'b1;
		errors       = 0;
	endfunction

	// 255*(x/255)^(g/100) by integer powers, blended over the hundredths
	function logic [bgc_pkg::LEVEL_W-1:0] corrected_level(
		input logic [bgc_pkg::LEVEL_W-1:0] x);
		longint unsigned n, f, xn, p255, lo, hi, y;
		n = gamma_cur / 100;
		f = gamma_cur % 100;
		if (x == 0 || x == bgc_pkg::LEVEL_MAX || gamma_cur == bgc_pkg::GAMMA_UNITY)
			return x;
		xn   = 1;
		p255 = 1;
		for (int i = 0; i < n; i++) begin
			xn   = xn * x;
			p255 = p255 * 255;
		end
		lo = (n == 0) ? 64'd255 : xn / (p255 / 255);
		hi = (xn * x) / p255;
		y  = (lo * (100 - f) + hi * f) / 100;
		if (y > bgc_pkg::LEVEL_MAX)
			y = bgc_pkg::LEVEL_MAX;
		return y[bgc_pkg::LEVEL_W-1:0];
	endfunction

	function void note_request(input bgc_pkg::func_t f,
		input logic [bgc_pkg::LEVEL_W-1:0] lv);
		panel_result_t r;
		case (f)
			bgc_pkg::FUNC_SET: begin
				stored_level = lv;
				if (lit) begin
					r = '{corrected_level(stored_level), 1'b1};
					pending_results.push_back(r);
				end
			end
			bgc_pkg::FUNC_OFF: begin
				lit = 1'b0;
				r = '{8'd0, 1'b0};
				pending_results.push_back(r);
			end
			bgc_pkg::FUNC_ON: begin
				lit = 1'b1;
				r = '{corrected_level(stored_level), 1'b1};
				pending_results.push_back(r);
			end
			default: begin
				if (lit) begin
					r = '{corrected_level(stored_level), 1'b1};
					pending_results.push_back(r);
				end
			end
		endcase
	endfunction

	function void check_result(input logic [bgc_pkg::LEVEL_W-1:0] dl, input logic on);
		panel_result_t e;
		if (pending_results.size() == 0) begin
			$display("%0t unexpected result: expected none, actual level %0d on %0d",
				$time, dl, on);
			errors++;
			return;
		end
		e = pending_results.pop_front();
		if (dl !== e.device_level) begin
			$display("%0t device_level mismatch: expected %0d actual %0d",
				$time, e.device_level, dl);
			errors++;
		end
		if (on !== e.display_on) begin
			$display("%0t display_on mismatch: expected %0d actual %0d",
				$time, e.display_on, on);
			errors++;
		end
	endfunction

	function int unsigned pending();
		return pending_results.size();
	endfunction
endclass

module backlight_gamma_controller_tb;

	// cycles without any request or result moving before the run is declared hung;
	// well above the long receiver hold-off and the idle pause before a gamma write
	localparam int unsigned STALL_LIMIT  = 5000;
	// settle time after the last result, longer than the slowest sequence
	localparam int unsigned DRAIN_CYCLES = 64;
	localparam int unsigned LONG_HOLD    = 400;
	localparam int unsigned NUM_PHASES   = 14;
	localparam int unsigned PHASE_ITEMS  = 125;
	localparam int unsigned PRESSURE_PHASE = 5;

	// idle patterns, percent of cycles
	localparam int unsigned IDLE_NONE = 0;
	localparam int unsigned IDLE_HIGH = 55;
	localparam int unsigned IDLE_BOTH = 21;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [bgc_pkg::GAMMA_W-1:0] cfg_wdata;

	bgc_req_if req_ch ();
	bgc_rsp_if rsp_ch ();

	backlight_gamma_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	panel_scoreboard levels = new();

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	logic        long_hold_req;

	// gamma values swept by the random phases: the legal extremes, values past
	// them on both ends, unity, and points just under an integer boundary
	logic [bgc_pkg::GAMMA_W-1:0] phase_gamma [NUM_PHASES] = '{
		9'd50, 9'd400, 9'd0, 9'd511, 9'd100, 9'd99, 9'd199,
		9'd150, 9'd250, 9'd333, 9'd499, 9'd0, 9'd0, 9'd275
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one request; it is taken at the first edge with ready high.
	// Valid stays up across back-to-back requests so it is never dropped and
	// raised in the same step.
	task automatic send_request(input bgc_pkg::func_t f,
		input logic [bgc_pkg::LEVEL_W-1:0] lv);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func  <= f;
		req_ch.level <= lv;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		levels.note_request(f, lv);
	endtask

	// Gamma may only change while the block is idle: drain every result, then
	// give a request with no result time to leave the sequencer.
	task automatic write_gamma(input logic [bgc_pkg::GAMMA_W-1:0] g);
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (levels.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= g;
		@(posedge clk);
		cfg_we <= 1'b0;
		levels.gamma_cur = g;
	endtask

	// Level sets for half the requests, with on/off/refresh mixed in; a few
	// levels land on the passthrough and near-passthrough corners.
	task automatic send_random_request();
		bgc_pkg::func_t              f;
		logic [bgc_pkg::LEVEL_W-1:0] lv;
		int unsigned                 pick;
		pick = $urandom_range(99);
		if (pick < 50)
			f = bgc_pkg::FUNC_SET;
		else if (pick < 62)
			f = bgc_pkg::FUNC_OFF;
		else if (pick < 78)
			f = bgc_pkg::FUNC_ON;
		else
			f = bgc_pkg::FUNC_REFRESH;
		case ($urandom_range(19))
			0:       lv = 8'd0;
			1:       lv = 8'd255;
			2:       lv = 8'd1;
			3:       lv = 8'd254;
			default: lv = bgc_pkg::LEVEL_W'($urandom_range(255));
		endcase
		send_request(f, lv);
	endtask

	// Result side: check what was taken at this edge, then decide ready for
	// the next one. A long hold-off requested by the stimulus is counted here.
	initial begin : result_sink
		int unsigned hold_cnt;
		hold_cnt = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				levels.check_result(rsp_ch.device_level, rsp_ch.display_on);
			if (long_hold_req) begin
				hold_cnt = LONG_HOLD;
				long_hold_req <= 1'b0;
			end
			if (hold_cnt != 0) begin
				hold_cnt--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Hang detector: any accepted request or result resets the count.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		int unsigned mode;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= '0;
		req_ch.valid  <= 1'b0;
		req_ch.func   <= bgc_pkg::FUNC_SET;
		req_ch.level  <= '0;
		long_hold_req <= 1'b0;
		send_idle_pct  = IDLE_NONE;
		recv_stall_pct <= IDLE_NONE;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset state: unity gamma, default level, screen lit.
		send_request(bgc_pkg::FUNC_REFRESH, 8'd0);
		send_request(bgc_pkg::FUNC_SET, 8'd37);
		send_request(bgc_pkg::FUNC_SET, 8'hAA);

		// Fractional gamma above 2: passthrough corners, near-corners, and
		// the screen-off rules (no result for set/refresh while dark).
		write_gamma(9'd220);
		send_request(bgc_pkg::FUNC_SET, 8'd0);
		send_request(bgc_pkg::FUNC_SET, 8'd255);
		send_request(bgc_pkg::FUNC_SET, 8'd1);
		send_request(bgc_pkg::FUNC_SET, 8'd254);
		send_request(bgc_pkg::FUNC_SET, 8'd128);
		send_request(bgc_pkg::FUNC_REFRESH, 8'h55);
		send_request(bgc_pkg::FUNC_OFF, 8'hFF);
		send_request(bgc_pkg::FUNC_SET, 8'd77);
		send_request(bgc_pkg::FUNC_REFRESH, 8'd0);
		send_request(bgc_pkg::FUNC_ON, 8'h0F);
		send_request(bgc_pkg::FUNC_OFF, 8'd0);
		send_request(bgc_pkg::FUNC_OFF, 8'd1);
		send_request(bgc_pkg::FUNC_ON, 8'hF0);
		send_request(bgc_pkg::FUNC_SET, 8'd200);

		// Gamma below 1.00 blends down from full scale.
		write_gamma(9'd50);
		send_request(bgc_pkg::FUNC_SET, 8'd10);
		send_request(bgc_pkg::FUNC_SET, 8'd254);
		send_request(bgc_pkg::FUNC_SET, 8'd2);

		// Random phases, one gamma each, cycling through the idle patterns.
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (phase_gamma[p] == 9'd0 && (p == 11 || p == 12))
				write_gamma(bgc_pkg::GAMMA_W'($urandom_range(511)));
			else
				write_gamma(phase_gamma[p]);
			mode = p % 4;
			send_idle_pct  = (mode == 1) ? IDLE_HIGH : (mode == 3) ? IDLE_BOTH : IDLE_NONE;
			recv_stall_pct <= (mode == 2) ? IDLE_HIGH : (mode == 3) ? IDLE_BOTH : IDLE_NONE;
			if (p == PRESSURE_PHASE) begin
				// receiver goes dark while requests keep coming, so the
				// result register and the sequencer both fill and req stalls
				send_idle_pct = IDLE_NONE;
				long_hold_req <= 1'b1;
			end
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_random_request();
		end

		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (levels.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (levels.errors == 0 && levels.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
